// ===== sv/stm_pkg.sv =====
// Shared types, constants and register codes for the spectrum trace block.
package stm_pkg;

  localparam int BIN_COUNT_DEF = 256;
  localparam int BIN_W         = 8;
  localparam int SAMPLE_W      = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [15:0] DECAY_RESET   = 16'd65208;
  localparam logic [15:0] WEIGHT_RESET  = 16'd6554;
  localparam logic [15:0] CEILING_RESET = 16'd19661;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DECAY   = 2'd0,
    REG_WEIGHT  = 2'd1,
    REG_CEILING = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] decay_factor;
    logic [15:0] average_weight;
    logic [15:0] power_ceiling;
  } cfg_t;

  // bins held by the two pipeline stages ahead of the memory write
  typedef struct packed {
    logic             a_valid;
    logic [BIN_W-1:0] a_bin;
    logic             b_valid;
    logic [BIN_W-1:0] b_bin;
  } flight_t;

  typedef struct packed {
    logic                we;
    logic [SAMPLE_W-1:0] peak;
    logic [SAMPLE_W-1:0] avg;
  } wr_t;

  typedef struct packed {
    logic [BIN_W-1:0]    out_bin;
    logic [SAMPLE_W-1:0] live_power;
    logic [SAMPLE_W-1:0] peak_hold;
    logic [SAMPLE_W-1:0] smoothed_power;
  } out_word_t;

endpackage

// ===== sv/stm_in_if.sv =====
// Sample channel: one bin sample per word.
interface stm_in_if;
  logic                         valid;
  logic                         ready;
  logic [stm_pkg::BIN_W-1:0]    bin_index;
  logic [stm_pkg::SAMPLE_W-1:0] power_sample;
  logic                         sweep_end;

  modport source (output valid, output bin_index, output power_sample, output sweep_end,
                  input ready);
  modport sink   (input valid, input bin_index, input power_sample, input sweep_end,
                  output ready);
endinterface

// ===== sv/stm_out_if.sv =====
// Result channel: live, max-hold and averaged power of one bin per word.
interface stm_out_if;
  logic                         valid;
  logic                         ready;
  logic [stm_pkg::BIN_W-1:0]    out_bin;
  logic [stm_pkg::SAMPLE_W-1:0] live_power;
  logic [stm_pkg::SAMPLE_W-1:0] peak_hold;
  logic [stm_pkg::SAMPLE_W-1:0] smoothed_power;

  modport source (output valid, output out_bin, output live_power, output peak_hold,
                  output smoothed_power, input ready);
  modport sink   (input valid, input out_bin, input live_power, input peak_hold,
                  input smoothed_power, output ready);
endinterface

// ===== sv/stm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/stm_regs.sv =====
// Configuration registers: decay factor, average weight and power ceiling.
module stm_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [stm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output stm_pkg::cfg_t                      cfg
);

  // load the addressed register, ignore unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_factor   <= stm_pkg::DECAY_RESET;
      cfg.average_weight <= stm_pkg::WEIGHT_RESET;
      cfg.power_ceiling  <= stm_pkg::CEILING_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        stm_pkg::REG_DECAY:   cfg.decay_factor   <= cfg_data;
        stm_pkg::REG_WEIGHT:  cfg.average_weight <= cfg_data;
        stm_pkg::REG_CEILING: cfg.power_ceiling  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/stm_calc.sv =====
// Three-stage update pipeline: clamp, multiply, blend and select.
module stm_calc #(
  parameter int BIN_COUNT = stm_pkg::BIN_COUNT_DEF,
  parameter int AW        = $clog2(BIN_COUNT)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         take,
  input  logic [stm_pkg::BIN_W-1:0]    in_bin,
  input  logic [stm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         first,
  input  stm_pkg::cfg_t                cfg,
  input  logic [stm_pkg::SAMPLE_W-1:0] peak_rd,
  input  logic [stm_pkg::SAMPLE_W-1:0] avg_rd,
  output stm_pkg::flight_t             flight,
  output stm_pkg::wr_t                 wr,
  output logic [AW-1:0]                wr_addr,
  output logic                         o_valid,
  output stm_pkg::out_word_t           o_word
);

  // stage A: clamped sample, memory data arrives alongside
  logic                         a_valid;
  logic [stm_pkg::BIN_W-1:0]    a_bin;
  logic [stm_pkg::SAMPLE_W-1:0] a_live;
  logic                         a_inr;
  logic                         a_first;

  // stage B: products and the max-hold decision
  logic                         b_valid;
  logic [stm_pkg::BIN_W-1:0]    b_bin;
  logic [stm_pkg::SAMPLE_W-1:0] b_live;
  logic                         b_inr;
  logic                         b_first;
  logic                         b_take;
  logic [stm_pkg::SAMPLE_W-1:0] b_dec;
  logic [stm_pkg::SAMPLE_W-1:0] b_avg;
  logic signed [33:0]           b_prod;

  logic [stm_pkg::SAMPLE_W-1:0] in_live;
  logic                         in_inr;
  logic [31:0]                  peak_prod;
  logic signed [16:0]           diff;
  logic signed [16:0]           weight_s;
  logic signed [33:0]           avg_prod;
  logic signed [17:0]           avg_sum;
  logic [stm_pkg::SAMPLE_W-1:0] peak_new;
  logic [stm_pkg::SAMPLE_W-1:0] avg_new;
  logic [31:0]                  b_bin_ext;

  // clamp to the ceiling and check the bin range
  assign in_live = (in_sample > cfg.power_ceiling) ? cfg.power_ceiling : in_sample;
  assign in_inr  = 32'(in_bin) < 32'(BIN_COUNT);

  // decay product and average step, avg + ((p - avg) * w) >>> 16
  assign peak_prod = 32'(peak_rd) * 32'(cfg.decay_factor);
  assign diff      = signed'({1'b0, a_live}) - signed'({1'b0, avg_rd});
  assign weight_s  = signed'({1'b0, cfg.average_weight});
  assign avg_prod  = diff * weight_s;

  // final values of stage B
  assign avg_sum  = signed'({2'b00, b_avg}) + signed'(b_prod[33:16]);
  assign peak_new = b_take ? b_live : b_dec;
  assign avg_new  = b_first ? b_live : avg_sum[15:0];

  // memory write back
  assign b_bin_ext = 32'(b_bin);
  assign wr_addr   = b_bin_ext[AW-1:0];
  assign wr.we     = en && b_valid && b_inr;
  assign wr.peak   = peak_new;
  assign wr.avg    = avg_new;

  assign flight.a_valid = a_valid;
  assign flight.a_bin   = a_bin;
  assign flight.b_valid = b_valid;
  assign flight.b_bin   = b_bin;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      a_valid <= take;
      b_valid <= a_valid;
      o_valid <= b_valid;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_bin   <= in_bin;
      a_live  <= in_live;
      a_inr   <= in_inr;
      a_first <= first;

      b_bin   <= a_bin;
      b_live  <= a_live;
      b_inr   <= a_inr;
      b_first <= a_first;
      b_take  <= a_live > peak_rd;
      b_dec   <= peak_prod[31:16];
      b_avg   <= avg_rd;
      b_prod  <= avg_prod;

      o_word.out_bin        <= b_bin;
      o_word.live_power     <= b_live;
      o_word.peak_hold      <= b_inr ? peak_new : '0;
      o_word.smoothed_power <= b_inr ? avg_new : '0;
    end
  end

endmodule

// ===== sv/spectrum_trace_max_hold_average.sv =====
// Spectrum trace max-hold and exponential averaging, top level.
//
// Takes one bin sample per clock when nothing holds the input back, and
// returns one result word per sample. An accepted sample moves through
// stage A and stage B into the result register, which drives the word
// onto the result channel. Each bin's max-hold and average live in two
// bin-indexed RAMs that are read when the sample is accepted and written
// as it leaves stage B, so a sample whose bin matches one of the two
// words still in flight waits until that write has landed; a sweep over
// distinct bins runs at one word per cycle while the result channel is
// not stalled. After reset the max-hold RAM is cleared one entry per
// cycle, all BIN_COUNT entries, during which no sample is accepted;
// configuration writes are taken throughout.
module spectrum_trace_max_hold_average #(
  parameter int BIN_COUNT = stm_pkg::BIN_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [stm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]  cfg_data,
  stm_in_if.sink                          samples,
  stm_out_if.source                       results
);

  localparam int AW = $clog2(BIN_COUNT);

  stm_pkg::cfg_t                cfg;
  stm_pkg::flight_t             flight;
  stm_pkg::wr_t                 wr;
  stm_pkg::out_word_t           o_word;
  logic [AW-1:0]                wr_addr;
  logic                         o_valid;
  logic                         en;
  logic                         hazard;
  logic                         take;
  logic                         first_sweep;
  logic                         clearing;
  logic [AW-1:0]                clr_addr;
  logic [31:0]                  in_bin_ext;
  logic [AW-1:0]                rd_addr;
  logic                         peak_we;
  logic [AW-1:0]                peak_waddr;
  logic [stm_pkg::SAMPLE_W-1:0] peak_wdata;
  logic [stm_pkg::SAMPLE_W-1:0] peak_rd;
  logic [stm_pkg::SAMPLE_W-1:0] avg_rd;

  stm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline moves whenever the output register is free or drained
  assign en = !o_valid || results.ready;

  // hold a sample whose bin is still being updated
  assign hazard = (flight.a_valid && (flight.a_bin == samples.bin_index)) ||
                  (flight.b_valid && (flight.b_bin == samples.bin_index));

  assign samples.ready = en && !clearing && !hazard;
  assign take          = samples.valid && samples.ready;

  assign in_bin_ext = 32'(samples.bin_index);
  assign rd_addr    = in_bin_ext[AW-1:0];

  // first sweep flag drops after the word that ends a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sweep <= 1'b1;
    end else if (take && samples.sweep_end) begin
      first_sweep <= 1'b0;
    end
  end

  // clear the max-hold RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(BIN_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign peak_we    = clearing || wr.we;
  assign peak_waddr = clearing ? clr_addr : wr_addr;
  assign peak_wdata = clearing ? '0 : wr.peak;

  stm_ram #(
    .WIDTH (stm_pkg::SAMPLE_W),
    .DEPTH (BIN_COUNT)
  ) u_peak_ram (
    .clk   (clk),
    .we    (peak_we),
    .waddr (peak_waddr),
    .wdata (peak_wdata),
    .re    (en),
    .raddr (rd_addr),
    .rdata (peak_rd)
  );

  stm_ram #(
    .WIDTH (stm_pkg::SAMPLE_W),
    .DEPTH (BIN_COUNT)
  ) u_avg_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr_addr),
    .wdata (wr.avg),
    .re    (en),
    .raddr (rd_addr),
    .rdata (avg_rd)
  );

  stm_calc #(
    .BIN_COUNT (BIN_COUNT),
    .AW        (AW)
  ) u_calc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .take      (take),
    .in_bin    (samples.bin_index),
    .in_sample (samples.power_sample),
    .first     (first_sweep),
    .cfg       (cfg),
    .peak_rd   (peak_rd),
    .avg_rd    (avg_rd),
    .flight    (flight),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .o_valid   (o_valid),
    .o_word    (o_word)
  );

  // drive the result channel
  assign results.valid          = o_valid;
  assign results.out_bin        = o_word.out_bin;
  assign results.live_power     = o_word.live_power;
  assign results.peak_hold      = o_word.peak_hold;
  assign results.smoothed_power = o_word.smoothed_power;

endmodule

// ===== sv/stm_checker.sv =====
// Port-level checks for the spectrum trace block, bound to the top level.
module stm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [stm_pkg::BIN_W-1:0]    in_bin,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stm_pkg::BIN_W-1:0]    out_bin,
  input logic [stm_pkg::SAMPLE_W-1:0] out_live,
  input logic [stm_pkg::SAMPLE_W-1:0] out_peak,
  input logic [stm_pkg::SAMPLE_W-1:0] out_avg
);

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_bin) && $stable(out_live) &&
                                $stable(out_peak) && $stable(out_avg))
    else $error("result payload changed while stalled");

  // the clearing pass blocks samples right after reset
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("sample accepted during clearing pass");

  // the same bin never enters on back-to-back cycles
  a_same_bin: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !(in_valid && in_ready && (in_bin == $past(in_bin))))
    else $error("back-to-back word for one bin");

endmodule

bind spectrum_trace_max_hold_average stm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_bin    (samples.bin_index),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_bin   (results.out_bin),
  .out_live  (results.live_power),
  .out_peak  (results.peak_hold),
  .out_avg   (results.smoothed_power)
);
